@@ rtl/core/cartesian_to_spherical_defines.svh @@
// ----------------------------------------------------------------------------
// cartesian_to_spherical assertion macros
// shared property forms for the conversion pipeline
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_SPHERICAL_DEFINES_SVH
`define CARTESIAN_TO_SPHERICAL_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define C2S_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("c2s check failed");

// next-cycle implication checked outside reset
`define C2S_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("c2s check failed");

`endif

@@ rtl/core/c2s_pkg.sv @@
// ----------------------------------------------------------------------------
// c2s_pkg
// shared constants, types and tables of the cartesian to spherical pipeline
// ----------------------------------------------------------------------------
package c2s_pkg;

	localparam int CORDIC_ITER_DEF = 20;
	localparam int ANG_W = 34;
	localparam int ROOT_W = 26;

	localparam logic [ANG_W-1:0] PI_Q30 = 34'd3373259426;
	localparam logic [ANG_W-1:0] HALFPI_Q30 = 34'd1686629713;
	localparam logic [ANG_W-1:0] TWOPI_Q30 = 34'd6746518852;
	localparam logic [ANG_W-1:0] THREEHALF_Q30 = 34'd5059889140;
	localparam logic [29:0] DEG_Q24 = 30'd961263669;
	localparam logic [24:0] RAD_FULL = 25'd411775;
	localparam logic [24:0] DEG_FULL = 25'd23592960;
	localparam logic [23:0] RAD_HALF = 24'd205887;
	localparam logic [23:0] DEG_HALF = 24'd11796480;

	typedef enum logic [1:0] {
		AZ_CORDIC = 2'd0,
		AZ_FIXED  = 2'd1
	} az_mode_t;

	// per-item side info that travels beside the root and cordic data
	typedef struct packed {
		logic x_neg;
		logic y_neg;
		logic z_neg;
		logic origin;
		logic az_fixed;
		logic pol_zero_b;
		logic pa_fixed;
		logic [ANG_W-1:0] az_fix_val;
		logic [ANG_W-1:0] pa_fix_val;
		logic deg;
	} side_t;

	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] t [32];
		t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
			32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
			32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
			32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
			32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
			32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
			32'h00000001, 32'h00000000};
		return t[i[4:0]];
	endfunction

endpackage

@@ rtl/core/c2s_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// c2s_sqrt_pipe
// pipelined restoring square root, one result bit per stage
// ----------------------------------------------------------------------------
module c2s_sqrt_pipe #(
	parameter int IN_W = 64,
	parameter int Q_W = 32,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IN_W-1:0]   radicand,
	input  logic [SIDE_W-1:0] side_in,
	output logic [Q_W-1:0]    root,
	output logic [Q_W+1:0]    rem_out,
	output logic [SIDE_W-1:0] side_out
);
	localparam int RW = Q_W + 2;
	localparam int NW = 2 * Q_W;

	logic [NW-1:0]     n_s1   [Q_W+1];
	logic [RW-1:0]     r_s1   [Q_W+1];
	logic [Q_W-1:0]    q_s1   [Q_W+1];
	logic [SIDE_W-1:0] sd_s1  [Q_W+1];

	always_comb begin
		n_s1[0] = NW'(radicand);
		r_s1[0] = '0;
		q_s1[0] = '0;
		sd_s1[0] = side_in;
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_st
		logic [RW-1:0] trial;
		logic [RW-1:0] rnext;
		logic          take;
		always_comb begin
			rnext = {r_s1[k][RW-3:0], n_s1[k][NW-1 -: 2]};
			trial = {q_s1[k][RW-3:0], 2'b01};
			take = rnext >= trial;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				n_s1[k+1] <= {n_s1[k][NW-3:0], 2'b00};
				r_s1[k+1] <= take ? rnext - trial : rnext;
				q_s1[k+1] <= {q_s1[k][Q_W-2:0], take};
				sd_s1[k+1] <= sd_s1[k];
			end
		end
	end

	assign root = q_s1[Q_W];
	assign rem_out = r_s1[Q_W];
	assign side_out = sd_s1[Q_W];
endmodule

@@ rtl/core/c2s_cordic_pipe.sv @@
// ----------------------------------------------------------------------------
// c2s_cordic_pipe
// first-quadrant vectoring cordic, one rotation per stage
// ----------------------------------------------------------------------------
module c2s_cordic_pipe #(
	parameter int ITER = c2s_pkg::CORDIC_ITER_DEF,
	parameter int IN_W = 32,
	parameter int SIDE_W = 8
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [IN_W-1:0]           a_in,
	input  logic [IN_W-1:0]           b_in,
	input  logic [SIDE_W-1:0]         side_in,
	output logic [c2s_pkg::ANG_W-1:0] ang_out,
	output logic [SIDE_W-1:0]         side_out
);
	import c2s_pkg::*;
	localparam int VW = IN_W + 25;
	localparam int AW = ANG_W + 2;

	logic signed [VW-1:0] xv_s1 [ITER+1];
	logic signed [VW-1:0] yv_s1 [ITER+1];
	logic signed [AW-1:0] an_s1 [ITER+1];
	logic                 bz_s1 [ITER+1];
	logic                 az_s1 [ITER+1];
	logic [SIDE_W-1:0]    sd_s1 [ITER+1];
	logic signed [AW-1:0] aclip;

	always_comb begin
		xv_s1[0] = VW'({a_in, 22'd0});
		yv_s1[0] = VW'({b_in, 22'd0});
		an_s1[0] = '0;
		bz_s1[0] = b_in == '0;
		az_s1[0] = a_in == '0;
		sd_s1[0] = side_in;
	end

	for (genvar i = 0; i < ITER; i++) begin : g_rot
		localparam logic [31:0] ATN = atan_q30(i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (yv_s1[i] >= 0) begin
					xv_s1[i+1] <= xv_s1[i] + (yv_s1[i] >>> i);
					yv_s1[i+1] <= yv_s1[i] - (xv_s1[i] >>> i);
					an_s1[i+1] <= an_s1[i] + AW'(ATN);
				end else begin
					xv_s1[i+1] <= xv_s1[i] - (yv_s1[i] >>> i);
					yv_s1[i+1] <= yv_s1[i] + (xv_s1[i] >>> i);
					an_s1[i+1] <= an_s1[i] - AW'(ATN);
				end
				bz_s1[i+1] <= bz_s1[i];
				az_s1[i+1] <= az_s1[i];
				sd_s1[i+1] <= sd_s1[i];
			end
		end
	end

	always_comb begin
		aclip = an_s1[ITER];
		if (aclip < 0) aclip = '0;
		if (aclip > $signed({2'b00, HALFPI_Q30})) aclip = $signed({2'b00, HALFPI_Q30});
		if (az_s1[ITER]) ang_out = HALFPI_Q30;
		else ang_out = aclip[ANG_W-1:0];
		if (bz_s1[ITER]) ang_out = '0;
	end
	assign side_out = sd_s1[ITER];
endmodule

@@ rtl/core/c2s_unit_conv.sv @@
// ----------------------------------------------------------------------------
// c2s_unit_conv
// angle to radians or degrees with rounding, two register stages
// ----------------------------------------------------------------------------
module c2s_unit_conv (
	input  logic                      clk,
	input  logic                      en,
	input  logic [c2s_pkg::ANG_W-1:0] ang,
	input  logic                      deg,
	output logic [24:0]               val
);
	import c2s_pkg::*;
	logic [63:0] prod_s1;
	logic [24:0] rad_s1;
	logic        deg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 64'(ang) * 64'(DEG_Q24);
			rad_s1 <= 25'((35'(ang) + 35'd8192) >> 14);
			deg_s1 <= deg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) val <= deg_s1 ? 25'((prod_s1 + 64'h20_0000_0000) >> 38) : rad_s1;
	end
endmodule

@@ rtl/core/cartesian_to_spherical.sv @@
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// point to radius, axis distance, polar angle and azimuth, fully pipelined
// ----------------------------------------------------------------------------
// channel   direction  signals
// in        sink       in_valid in_ready x_coord y_coord z_coord
// out       source     out_valid out_ready radius axis_distance polar_angle azimuth
// cfg       sink       cfg_valid cfg_ready cfg_data
//
// one item per cycle unless the output stalls; the path runs through the input
// register, both root chains, the polar cordic and the unit and output registers.
// reset clears valid bits and the unit register. a stall freezes the whole pipe,
// so nothing is lost.
// ----------------------------------------------------------------------------
module cartesian_to_spherical #(
	parameter int CORDIC_ITERATIONS = c2s_pkg::CORDIC_ITER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [23:0] x_coord,
	input  logic signed [23:0] y_coord,
	input  logic signed [23:0] z_coord,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] radius,
	output logic [23:0] axis_distance,
	output logic [23:0] polar_angle,
	output logic [24:0] azimuth,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import c2s_pkg::*;
	`include "cartesian_to_spherical_defines.svh"

	localparam int SQ1 = 26;
	localparam int SQ2 = 33;
	localparam int DEPTH = 1 + SQ1 + SQ2 + CORDIC_ITERATIONS + 3;
	localparam int SW = $bits(side_t);

	logic deg_q;
	logic en;
	logic [DEPTH-1:0] vld_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) deg_q <= 1'b0;
		else if (cfg_valid) deg_q <= cfg_data;
	end

	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[DEPTH-2:0], in_valid};
	end

	// stage 1: magnitudes, squares and special cases
	logic [23:0] ax_s1, ay_s1, az_s1;
	logic [48:0] sxy_s1;
	logic [49:0] sr_s1;
	side_t sd_s1;
	logic [23:0] ax, ay, az;
	side_t sd;
	always_comb begin
		ax = x_coord[23] ? 24'(-x_coord) : x_coord;
		ay = y_coord[23] ? 24'(-y_coord) : y_coord;
		az = z_coord[23] ? 24'(-z_coord) : z_coord;
		sd = '0;
		sd.x_neg = x_coord[23];
		sd.y_neg = y_coord[23];
		sd.z_neg = z_coord[23];
		sd.origin = x_coord == 0 && y_coord == 0 && z_coord == 0;
		sd.deg = deg_q;
		sd.az_fixed = x_coord == 0 || y_coord == 0;
		if (x_coord == 0) sd.az_fix_val = y_coord[23] ? THREEHALF_Q30 : HALFPI_Q30;
		else sd.az_fix_val = x_coord[23] ? PI_Q30 : '0;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= ax;
			ay_s1 <= ay;
			az_s1 <= az;
			sxy_s1 <= 49'(48'(ax) * 48'(ax)) + 49'(48'(ay) * 48'(ay));
			sr_s1 <= 50'(48'(ax) * 48'(ax)) + 50'(48'(ay) * 48'(ay)) +
				50'(48'(az) * 48'(az));
			sd_s1 <= sd;
		end
	end

	// root chain one: rho and r side by side
	localparam int SD1 = 24 + 24 + 24 + 50 + SW;
	logic [SQ1-1:0] rho_f, r_f;
	logic [SQ1+1:0] rho_rem, r_rem;
	logic [SD1-1:0] c1_out, c1_dummy;
	logic [23:0] ax_s2, ay_s2, az_s2;
	logic [49:0] sxy_s2;
	side_t sd_s2;

	c2s_sqrt_pipe #(.IN_W(52), .Q_W(SQ1), .SIDE_W(SD1)) u_sq_rho (
		.clk, .en, .radicand(52'(sxy_s1)),
		.side_in({ax_s1, ay_s1, az_s1, 50'(sxy_s1), sd_s1}),
		.root(rho_f), .rem_out(rho_rem), .side_out(c1_out)
	);
	c2s_sqrt_pipe #(.IN_W(52), .Q_W(SQ1), .SIDE_W(SD1)) u_sq_r (
		.clk, .en, .radicand(52'(sr_s1)),
		.side_in('0), .root(r_f), .rem_out(r_rem), .side_out(c1_dummy)
	);
	assign {ax_s2, ay_s2, az_s2, sxy_s2, sd_s2} = c1_out;

	// rounding: n - s^2 > s means round up
	logic [23:0] rho_rnd, r_rnd;
	always_comb begin
		rho_rnd = 24'(rho_f + SQ1'(28'(rho_rem) > 28'(rho_f)));
		r_rnd = 24'(r_f + SQ1'(28'(r_rem) > 28'(r_f)));
	end

	// root chain two: rho in Q8, ahead of both cordics
	localparam int SD2 = 24 + 24 + 24 + 24 + 24 + SW;
	logic [SQ2-1:0] rho8;
	logic [SQ2+1:0] rho8_rem;
	logic [SD2-1:0] c2_out;
	logic [23:0] ax_s3, ay_s3, az_s3, rho_s3, r_s3;
	side_t sd_s3;
	c2s_sqrt_pipe #(.IN_W(66), .Q_W(SQ2), .SIDE_W(SD2)) u_sq_rho8 (
		.clk, .en, .radicand({sxy_s2, 16'd0}),
		.side_in({ax_s2, ay_s2, az_s2, rho_rnd, r_rnd, sd_s2}),
		.root(rho8), .rem_out(rho8_rem), .side_out(c2_out)
	);
	assign {ax_s3, ay_s3, az_s3, rho_s3, r_s3, sd_s3} = c2_out;

	// two cordics side by side
	localparam int SD3 = 24 + 24 + SW;
	logic [ANG_W-1:0] t_pol, t_az;
	logic [SD3-1:0] c3_out, c3_dummy;
	logic [23:0] rho_s4, r_s4;
	side_t sd_s4;
	c2s_cordic_pipe #(.ITER(CORDIC_ITERATIONS), .IN_W(33), .SIDE_W(SD3)) u_cor_pol (
		.clk, .en, .a_in({1'b0, az_s3, 8'd0}), .b_in(rho8),
		.side_in({rho_s3, r_s3, sd_s3}), .ang_out(t_pol), .side_out(c3_out)
	);
	c2s_cordic_pipe #(.ITER(CORDIC_ITERATIONS), .IN_W(33), .SIDE_W(SD3)) u_cor_az (
		.clk, .en, .a_in(33'(ax_s3)), .b_in(33'(ay_s3)),
		.side_in('0), .ang_out(t_az), .side_out(c3_dummy)
	);
	assign {rho_s4, r_s4, sd_s4} = c3_out;

	// quadrant folding
	logic [ANG_W-1:0] pa, aa;
	always_comb begin
		if (sd_s4.origin) pa = '0;
		else pa = sd_s4.z_neg ? PI_Q30 - t_pol : t_pol;
		if (sd_s4.az_fixed) aa = sd_s4.az_fix_val;
		else if (!sd_s4.x_neg && !sd_s4.y_neg) aa = t_az;
		else if (sd_s4.x_neg && !sd_s4.y_neg) aa = PI_Q30 - t_az;
		else if (sd_s4.x_neg) aa = PI_Q30 + t_az;
		else aa = TWOPI_Q30 - t_az;
	end

	logic [24:0] pol_u, az_u;
	logic [23:0] rho_s5, r_s5, rho_s6, r_s6;
	logic deg_s5, deg_s6;
	c2s_unit_conv u_conv_pol (.clk, .en, .ang(pa), .deg(sd_s4.deg), .val(pol_u));
	c2s_unit_conv u_conv_az (.clk, .en, .ang(aa), .deg(sd_s4.deg), .val(az_u));
	always_ff @(posedge clk) begin
		if (en) begin
			rho_s5 <= rho_s4;
			r_s5 <= r_s4;
			deg_s5 <= sd_s4.deg;
			rho_s6 <= rho_s5;
			r_s6 <= r_s5;
			deg_s6 <= deg_s5;
		end
	end

	// final clamp and output register
	logic [24:0] pol_lim, az_full;
	always_comb begin
		pol_lim = deg_s6 ? 25'(DEG_HALF) : 25'(RAD_HALF);
		az_full = deg_s6 ? DEG_FULL : RAD_FULL;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			radius <= r_s6;
			axis_distance <= rho_s6;
			polar_angle <= 24'((pol_u > pol_lim) ? pol_lim : pol_u);
			azimuth <= (az_u >= az_full) ? 25'd0 : az_u;
		end
	end

	`C2S_ASSERT_IMPL(a_stall_hold, clk, arst_n, out_valid && !out_ready, !in_ready)
	`C2S_ASSERT_NEXT(a_stall_keep, clk, arst_n, out_valid && !out_ready, out_valid)
	`C2S_ASSERT_IMPL(a_rad_range, clk, arst_n, out_valid, radius >= axis_distance)
	`C2S_ASSERT_IMPL(a_az_range, clk, arst_n, out_valid, azimuth < DEG_FULL)
endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives signed points through cartesian_to_spherical in both angle units and
// checks every result against a bit-exact integer square root and cordic
// model, with random gaps on the input side and random stalls on the output
// ----------------------------------------------------------------------------
module tb;
	import c2s_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 2 * 33 + CORDIC_ITER_DEF + 4 + 20;

	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
	} point_t;

	typedef struct {
		logic [23:0] radius;
		logic [23:0] axis_distance;
		logic [23:0] polar_angle;
		logic [24:0] azimuth;
	} sph_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [23:0] x_coord;
	logic signed [23:0] y_coord;
	logic signed [23:0] z_coord;
	logic out_valid;
	logic out_ready;
	logic [23:0] radius;
	logic [23:0] axis_distance;
	logic [23:0] polar_angle;
	logic [24:0] azimuth;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	point_t pending_points[$];
	sph_t expected_coords[$];
	bit deg_mode;
	bit hold_send;
	bit no_gaps;
	bit no_stalls;
	int send_gap;
	int recv_stall;
	int errors;
	int idle_cycles;

	cartesian_to_spherical u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.z_coord(z_coord),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.radius(radius),
		.axis_distance(axis_distance),
		.polar_angle(polar_angle),
		.azimuth(azimuth),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned sqrt_floor(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned sqrt_nearest(longint unsigned n);
		longint unsigned s;
		s = sqrt_floor(n);
		return (s * s + s < n) ? s + 1 : s;
	endfunction

	// first-quadrant atan(b/a) in q30 radians
	function automatic longint vector_angle(longint unsigned a, longint unsigned b);
		longint xv;
		longint yv;
		longint ang;
		longint xs;
		longint ys;
		if (b == 0)
			return 0;
		if (a == 0)
			return longint'(HALFPI_Q30);
		xv = longint'(a << 22);
		yv = longint'(b << 22);
		ang = 0;
		for (int i = 0; i < CORDIC_ITER_DEF && i < 32; i++) begin
			xs = xv >>> i;
			ys = yv >>> i;
			if (yv >= 0) begin
				xv = xv + ys;
				yv = yv - xs;
				ang = ang + longint'(atan_q30(i));
			end else begin
				xv = xv - ys;
				yv = yv + xs;
				ang = ang - longint'(atan_q30(i));
			end
		end
		if (ang < 0)
			ang = 0;
		if (ang > longint'(HALFPI_Q30))
			ang = longint'(HALFPI_Q30);
		return ang;
	endfunction

	function automatic longint unsigned angle_scaled(longint a, bit deg);
		longint unsigned u;
		u = (a < 0) ? 0 : longint'(a);
		if (deg)
			return (u * longint'(DEG_Q24) + (64'd1 << 37)) >> 38;
		return (u + (64'd1 << 13)) >> 14;
	endfunction

	function automatic sph_t spherical_of(point_t p, bit deg);
		longint sx;
		longint sy;
		longint sz;
		longint unsigned ax;
		longint unsigned ay;
		longint unsigned az;
		longint unsigned sxy;
		longint unsigned pol;
		longint unsigned azi;
		longint pa;
		longint aa;
		longint t;
		sph_t r;
		sx = p.x;
		sy = p.y;
		sz = p.z;
		ax = (sx < 0) ? -sx : sx;
		ay = (sy < 0) ? -sy : sy;
		az = (sz < 0) ? -sz : sz;
		sxy = ax * ax + ay * ay;
		if (sxy == 0 && az == 0) begin
			pa = 0;
		end else begin
			t = vector_angle(az << 8, sqrt_floor(sxy << 16));
			pa = (sz >= 0) ? t : longint'(PI_Q30) - t;
		end
		if (sx == 0) begin
			aa = (sy >= 0) ? longint'(HALFPI_Q30) : longint'(THREEHALF_Q30);
		end else if (sy == 0) begin
			aa = (sx > 0) ? 0 : longint'(PI_Q30);
		end else begin
			t = vector_angle(ax, ay);
			if (sx > 0 && sy > 0)
				aa = t;
			else if (sx < 0 && sy > 0)
				aa = longint'(PI_Q30) - t;
			else if (sx < 0)
				aa = longint'(PI_Q30) + t;
			else
				aa = longint'(TWOPI_Q30) - t;
		end
		pol = angle_scaled(pa, deg);
		if (pol > (deg ? longint'(DEG_HALF) : longint'(RAD_HALF)))
			pol = deg ? longint'(DEG_HALF) : longint'(RAD_HALF);
		azi = angle_scaled(aa, deg);
		if (azi >= (deg ? longint'(DEG_FULL) : longint'(RAD_FULL)))
			azi = 0;
		r.radius = 24'(sqrt_nearest(sxy + az * az));
		r.axis_distance = 24'(sqrt_nearest(sxy));
		r.polar_angle = 24'(pol);
		r.azimuth = 25'(azi);
		return r;
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			x_coord <= '0;
			y_coord <= '0;
			z_coord <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_coords.push_back(spherical_of('{x_coord, y_coord, z_coord}, deg_mode));
			if (!(in_valid && !in_ready)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_points.size() > 0 && !hold_send) begin
					point_t p;
					p = pending_points.pop_front();
					x_coord <= p.x;
					y_coord <= p.y;
					z_coord <= p.z;
					in_valid <= 1'b1;
					send_gap <= no_gaps ? 0 : $urandom_range(0, 19);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_coords.size() == 0) begin
					$display("unexpected item at %0t", $time);
					errors++;
				end else begin
					sph_t e;
					e = expected_coords.pop_front();
					if (radius !== e.radius)
						report("radius", radius, e.radius);
					if (axis_distance !== e.axis_distance)
						report("axis_distance", axis_distance, e.axis_distance);
					if (polar_angle !== e.polar_angle)
						report("polar_angle", polar_angle, e.polar_angle);
					if (azimuth !== e.azimuth)
						report("azimuth", azimuth, e.azimuth);
				end
			end
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				out_ready <= (recv_stall == 1);
			end else if (out_valid && out_ready) begin
				int stall;
				stall = no_stalls ? 0 : $urandom_range(0, 19);
				recv_stall <= stall;
				out_ready <= (stall == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_unit(bit deg);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= deg;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		deg_mode = deg;
	endtask

	task automatic drain();
		while (pending_points.size() > 0 || in_valid || expected_coords.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 24'(signed'($urandom_range(0, 30)) - 15);
			1: return '0;
			2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			3: return 24'(signed'($urandom_range(0, 2000)) - 1000);
			default: return 24'($urandom());
		endcase
	endfunction

	task automatic push_directed();
		point_t d[$];
		d = '{'{0, 0, 0}, '{24'sh7FFFFF, 0, 0}, '{24'sh800000, 0, 0},
			'{0, 24'sh7FFFFF, 0}, '{0, 24'sh800000, 0}, '{0, 0, 24'sh7FFFFF},
			'{0, 0, 24'sh800000}, '{24'sh800000, 24'sh800000, 24'sh800000},
			'{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF}, '{-1, 0, 0}, '{0, -1, 0},
			'{24'sh7FFFFF, -1, 0}, '{24'sh7FFFFF, -1, 5}, '{1, 0, 24'sh800001},
			'{1, 0, 24'sh7FFFFF}, '{-5, 3, 7}, '{3, -4, 12}, '{-7, -2, 1},
			'{1, 1, 1}, '{24'sh800000, 24'sh7FFFFF, -3}, '{0, 0, -1}, '{0, 0, 1}};
		foreach (d[i])
			pending_points.push_back(d[i]);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		deg_mode = 1'b0;
		hold_send = 1'b0;
		no_gaps = 1'b0;
		no_stalls = 1'b0;
		errors = 0;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_directed();
		drain();
		write_unit(1'b1);
		push_directed();
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_unit(ph[0]);
			@(negedge clk);
			no_gaps = (ph == 2);
			no_stalls = (ph == 2 || ph == 4);
			for (int i = 0; i < 200; i++) begin
				point_t p;
				p.x = rand_coord();
				p.y = rand_coord();
				p.z = rand_coord();
				pending_points.push_back(p);
			end
			if (ph == 3) begin
				while (pending_points.size() > 100)
					@(negedge clk);
				hold_send = 1'b1;
				while (in_valid || expected_coords.size() > 0)
					@(negedge clk);
				hold_send = 1'b0;
			end
			drain();
		end

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
